/* design/bea_pkg.sv */
package bea_pkg;

  localparam int MAX_DEVICES    = 8;
  localparam int NUM_ACTIVITIES = 4;

  localparam int OP_W     = 2;
  localparam int TIME_W   = 32;
  localparam int SLOT_W   = 3;
  localparam int ACT_W    = 2;
  localparam int CUR_W    = 20;
  localparam int VOLT_W   = 16;
  localparam int E_W      = 56;
  localparam int STAT_W   = 2;
  localparam int CFG_IX_W = 2;

  localparam int DEV_W  = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int CUR_AW = DEV_W + ACT_W;
  localparam int CUR_DEPTH = MAX_DEVICES * NUM_ACTIVITIES;

  // multiply-accumulate widths
  localparam int SUM_W  = 64;
  localparam int P1_W   = CUR_W + VOLT_W;
  localparam int HALF_W = P1_W / 2;
  localparam int MA_W   = (CUR_W > HALF_W) ? CUR_W : HALF_W;
  localparam int MB_W   = (TIME_W > VOLT_W) ? TIME_W : VOLT_W;
  localparam int MP_W   = MA_W + MB_W;
  localparam int PP_W   = HALF_W + TIME_W;
  localparam int COMB_W = P1_W + TIME_W;

  localparam logic [VOLT_W-1:0] VOLT_RESET = VOLT_W'(3000);
  localparam logic [E_W-1:0]    CAP_RESET  = E_W'(64'd26640000000000000);
  localparam logic [E_W-1:0]    THR_RESET  = E_W'(64'd266400000000000);

  localparam logic [CFG_IX_W-1:0] CFG_VOLT = CFG_IX_W'(0);
  localparam logic [CFG_IX_W-1:0] CFG_CAP  = CFG_IX_W'(1);
  localparam logic [CFG_IX_W-1:0] CFG_THR  = CFG_IX_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_REG  = 2'd0,
    OP_ACT  = 2'd1,
    OP_TICK = 2'd2,
    OP_PUB  = 2'd3
  } opcode_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_IDLE = 2'd0,
    ACT_RX   = 2'd1,
    ACT_TX   = 2'd2,
    ACT_SLEEP = 2'd3
  } activity_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_DUP   = 2'd1,
    STAT_UNREG = 2'd2,
    STAT_DEAD  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    MAC_HOLD,
    MAC_CLEAR,
    MAC_VOLT,
    MAC_LO,
    MAC_HI,
    MAC_COMB,
    MAC_ACC
  } mac_step_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REG,
    ST_SCAN,
    ST_VOLT,
    ST_LO,
    ST_HI,
    ST_COMB,
    ST_ACC,
    ST_FIN,
    ST_SNAP,
    ST_CUR,
    ST_DRAW,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [TIME_W-1:0] now_time;
    logic [SLOT_W-1:0] device_slot;
    logic [ACT_W-1:0]  activity;
    logic [CUR_W-1:0]  idle_current;
    logic [CUR_W-1:0]  receive_current;
    logic [CUR_W-1:0]  transmit_current;
    logic [CUR_W-1:0]  sleep_current;
  } item_t;

  typedef struct packed {
    logic [E_W-1:0]    residual_out;
    logic [E_W-1:0]    snapshot_out;
    logic              depleted;
    logic [TIME_W-1:0] depletion_time;
    logic [STAT_W-1:0] status;
  } result_t;

endpackage

/* design/battery_energy_accountant_unit.sv */
// A register item writes its four currents, then its result shows; an ignored or
// rejected item goes straight to its result; any other item walks the slots through
// the shared multiplier (volt, lo, hi, comb, acc per active registered slot), updates
// residual, checks the snapshot unless it depletes, and stores an activity change's draw.
// Throughput: one item at a time; the next is taken in the cycle the result shows.
// Reset (rst, synchronous): registers to defaults, residual and snapshot to full
// capacity, no slot registered; the receiver cannot stall, done is a 1-cycle strobe.
module battery_energy_accountant_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  bea_pkg::item_t               item,
  output logic                         busy,
  output logic                         done,
  output bea_pkg::result_t             result,
  input  logic                         cfg_we,
  input  logic [bea_pkg::CFG_IX_W-1:0] cfg_index,
  input  logic [bea_pkg::E_W-1:0]      cfg_data
);
  import bea_pkg::*;

  localparam logic [DEV_W-1:0] DEV_LAST = DEV_W'(MAX_DEVICES - 1);
  localparam logic [ACT_W-1:0] ACT_LAST = ACT_W'(NUM_ACTIVITIES - 1);

  state_t            state;
  state_t            state_next;
  item_t             item_r;
  status_t           stat;
  status_t           acc_stat;
  logic [TIME_W-1:0] dt;
  logic [DEV_W-1:0]  idx;
  logic [ACT_W-1:0]  cnt;
  logic [VOLT_W-1:0] volt;
  logic [E_W-1:0]    thr;
  logic [E_W-1:0]    residual;
  logic [E_W-1:0]    snapshot;
  logic [TIME_W-1:0] last_time;
  logic [MAX_DEVICES-1:0] slot_valid;
  logic [MAX_DEVICES-1:0] slot_active;
  logic              dead_flag;
  logic [TIME_W-1:0] death;

  logic              accept;
  logic [DEV_W-1:0]  in_dev;
  logic              in_range;
  logic              dead_now;
  logic [DEV_W-1:0]  dev_r;
  logic              dies;
  logic [E_W-1:0]    snap_gap;

  mac_step_t         mac_step;
  logic [SUM_W-1:0]  total;

  logic              cur_we;
  logic [CUR_AW-1:0] cur_waddr;
  logic [CUR_W-1:0]  cur_wdata;
  logic              cur_re;
  logic [CUR_AW-1:0] cur_raddr;
  logic [CUR_W-1:0]  cur_rdata;
  logic              draw_we;
  logic              draw_re;
  logic [DEV_W-1:0]  draw_raddr;
  logic [CUR_W-1:0]  draw_rdata;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign in_dev   = DEV_W'(item.device_slot);
  assign in_range = 32'(item.device_slot) < MAX_DEVICES;
  assign dead_now = dead_flag || (residual == '0);
  assign dev_r    = DEV_W'(item_r.device_slot);
  assign dies     = total >= SUM_W'(residual);
  assign snap_gap = snapshot - residual;

  bea_ram #(.WIDTH(CUR_W), .DEPTH(CUR_DEPTH)) u_cur_ram (
    .clk   (clk),
    .we    (cur_we),
    .waddr (cur_waddr),
    .wdata (cur_wdata),
    .re    (cur_re),
    .raddr (cur_raddr),
    .rdata (cur_rdata)
  );

  bea_ram #(.WIDTH(CUR_W), .DEPTH(MAX_DEVICES)) u_draw_ram (
    .clk   (clk),
    .we    (draw_we),
    .waddr (dev_r),
    .wdata (cur_rdata),
    .re    (draw_re),
    .raddr (draw_raddr),
    .rdata (draw_rdata)
  );

  bea_mac u_mac (
    .clk   (clk),
    .step  (mac_step),
    .draw  (draw_rdata),
    .volt  (volt),
    .dt    (dt),
    .total (total)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    acc_stat   = STAT_OK;
    mac_step   = MAC_HOLD;
    cur_we     = 1'b0;
    cur_waddr  = {dev_r, cnt};
    cur_re     = 1'b0;
    cur_raddr  = {dev_r, item_r.activity};
    draw_we    = 1'b0;
    draw_re    = 1'b0;
    draw_raddr = idx;
    case (cnt)
      ACT_IDLE: cur_wdata = item_r.idle_current;
      ACT_RX:   cur_wdata = item_r.receive_current;
      ACT_TX:   cur_wdata = item_r.transmit_current;
      default:  cur_wdata = item_r.sleep_current;
    endcase

    case (state)
      ST_IDLE: begin
        if (start) begin
          mac_step = MAC_CLEAR;
          if (dead_now) begin
            acc_stat   = STAT_DEAD;
            state_next = ST_DONE;
          end else begin
            case (item.opcode)
              OP_REG: begin
                if (!in_range) begin
                  acc_stat   = STAT_UNREG;
                  state_next = ST_DONE;
                end else if (slot_valid[in_dev]) begin
                  acc_stat   = STAT_DUP;
                  state_next = ST_DONE;
                end else begin
                  state_next = ST_REG;
                end
              end
              OP_ACT: begin
                if (!in_range || !slot_valid[in_dev]) begin
                  acc_stat   = STAT_UNREG;
                  state_next = ST_DONE;
                end else begin
                  state_next = ST_SCAN;
                end
              end
              default: state_next = ST_SCAN;
            endcase
          end
        end
      end
      ST_REG: begin
        cur_we = 1'b1;
        if (cnt == ACT_LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_SCAN: begin
        // skip slots with nothing to draw
        if (slot_valid[idx] && slot_active[idx]) begin
          draw_re    = 1'b1;
          state_next = ST_VOLT;
        end else if (idx == DEV_LAST) begin
          state_next = ST_FIN;
        end
      end
      ST_VOLT: begin
        mac_step   = MAC_VOLT;
        state_next = ST_LO;
      end
      ST_LO: begin
        mac_step   = MAC_LO;
        state_next = ST_HI;
      end
      ST_HI: begin
        mac_step   = MAC_HI;
        state_next = ST_COMB;
      end
      ST_COMB: begin
        mac_step   = MAC_COMB;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        mac_step   = MAC_ACC;
        state_next = (idx == DEV_LAST) ? ST_FIN : ST_SCAN;
      end
      ST_FIN: begin
        if (!dies) begin
          state_next = ST_SNAP;
        end else if (item_r.opcode == OP_ACT) begin
          state_next = ST_CUR;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SNAP: begin
        state_next = (item_r.opcode == OP_ACT) ? ST_CUR : ST_DONE;
      end
      ST_CUR: begin
        cur_re     = 1'b1;
        state_next = ST_DRAW;
      end
      ST_DRAW: begin
        draw_we    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volt        <= VOLT_RESET;
      thr         <= THR_RESET;
      residual    <= CAP_RESET;
      snapshot    <= CAP_RESET;
      last_time   <= '0;
      slot_valid  <= '0;
      slot_active <= '0;
      dead_flag   <= 1'b0;
      death       <= '0;
      done        <= 1'b0;
    end else begin
      done <= (state == ST_DONE);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            item_r <= item;
            stat   <= acc_stat;
            idx    <= '0;
            cnt    <= '0;
            dt     <= (item.now_time >= last_time) ? item.now_time - last_time : '0;
          end
        end
        ST_REG: begin
          cnt <= cnt + ACT_W'(1);
          if (cnt == ACT_LAST) begin
            slot_valid[dev_r] <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (!(slot_valid[idx] && slot_active[idx]) && idx != DEV_LAST) begin
            idx <= idx + DEV_W'(1);
          end
        end
        ST_ACC: begin
          if (idx != DEV_LAST) begin
            idx <= idx + DEV_W'(1);
          end
        end
        ST_FIN: begin
          last_time <= item_r.now_time;
          if (dies) begin
            residual  <= '0;
            dead_flag <= 1'b1;
            death     <= item_r.now_time;
          end else begin
            residual <= residual - total[E_W-1:0];
          end
        end
        ST_SNAP: begin
          if (item_r.opcode == OP_PUB ||
              (snapshot >= residual && snap_gap >= thr)) begin
            snapshot <= residual;
          end
        end
        ST_DRAW: begin
          slot_active[dev_r] <= 1'b1;
        end
        ST_DONE: begin
          result.residual_out   <= residual;
          result.snapshot_out   <= snapshot;
          result.depleted       <= dead_flag;
          result.depletion_time <= dead_flag ? death : '0;
          result.status         <= stat;
        end
        default: ;
      endcase

      // a capacity write reloads the energy counters
      if (cfg_we) begin
        case (cfg_index)
          CFG_VOLT: volt <= cfg_data[VOLT_W-1:0];
          CFG_CAP: begin
            residual <= cfg_data;
            snapshot <= cfg_data;
          end
          CFG_THR: thr <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

/* design/bea_ram.sv */
module bea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/bea_mac.sv */
module bea_mac (
  input  logic                       clk,
  input  bea_pkg::mac_step_t         step,
  input  logic [bea_pkg::CUR_W-1:0]  draw,
  input  logic [bea_pkg::VOLT_W-1:0] volt,
  input  logic [bea_pkg::TIME_W-1:0] dt,
  output logic [bea_pkg::SUM_W-1:0]  total
);
  import bea_pkg::*;

  logic [MA_W-1:0]   ma;
  logic [MB_W-1:0]   mb;
  logic [MP_W-1:0]   prod;
  logic [P1_W-1:0]   p1;
  logic [PP_W-1:0]   plo;
  logic [PP_W-1:0]   phi;
  logic [COMB_W-1:0] comb;
  logic [SUM_W-1:0]  p_sat;
  logic [SUM_W:0]    acc_sum;
  logic [SUM_W-1:0]  acc_next;

  // one shared multiplier: draw*volt first, then the two halves of that times dt
  always_comb begin
    case (step)
      MAC_VOLT: begin
        ma = MA_W'(draw);
        mb = MB_W'(volt);
      end
      MAC_LO: begin
        ma = MA_W'(p1[HALF_W-1:0]);
        mb = MB_W'(dt);
      end
      MAC_HI: begin
        ma = MA_W'(p1[P1_W-1:HALF_W]);
        mb = MB_W'(dt);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = MP_W'(ma) * MP_W'(mb);

  // saturate the product to 64 bits, then saturate the running sum
  assign p_sat    = (|comb[COMB_W-1:SUM_W]) ? '1 : comb[SUM_W-1:0];
  assign acc_sum  = {1'b0, total} + {1'b0, p_sat};
  assign acc_next = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];

  always_ff @(posedge clk) begin
    case (step)
      MAC_CLEAR: total <= '0;
      MAC_VOLT:  p1    <= prod[P1_W-1:0];
      MAC_LO:    plo   <= prod[PP_W-1:0];
      MAC_HI:    phi   <= prod[PP_W-1:0];
      MAC_COMB:  comb  <= COMB_W'(plo) + {phi, HALF_W'(0)};
      MAC_ACC:   total <= acc_next;
      default: ;
    endcase
  end

endmodule

/* design/bea_checker.sv */
module bea_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input bea_pkg::result_t             result
);
  import bea_pkg::*;

  // every accepted beat raises busy in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // results never show in consecutive cycles
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // a result shows only once the unit is free for the next beat
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // depletion time reads zero until depletion
  a_death_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.depleted) |-> (result.depletion_time == '0))
    else $error("depletion time set while not depleted");

endmodule

bind battery_energy_accountant_unit bea_checker u_bea_checker (.*);

/* test/tb.sv */
`timescale 1ns / 100ps

import bea_pkg::*;

class gauge_board;
  localparam logic [2:0] NO_ACTIVITY = 3'd4;

  logic [VOLT_W-1:0] volt;
  logic [E_W-1:0]    capacity;
  logic [E_W-1:0]    threshold;
  logic [E_W-1:0]    residual;
  logic [E_W-1:0]    snapshot;
  logic [TIME_W-1:0] last_t;
  logic [TIME_W-1:0] dead_t;
  bit                dead;
  bit                slot_on [MAX_DEVICES];
  logic [CUR_W-1:0]  currents [CUR_DEPTH];
  logic [2:0]        mode [MAX_DEVICES];
  logic [CUR_W-1:0]  draw [MAX_DEVICES];
  result_t           readings [$];
  int                errors;

  function new();
    volt      = VOLT_RESET;
    capacity  = CAP_RESET;
    threshold = THR_RESET;
    residual  = CAP_RESET;
    snapshot  = CAP_RESET;
    last_t    = '0;
    dead_t    = '0;
    dead      = 0;
    errors    = 0;
    for (int i = 0; i < MAX_DEVICES; i++) begin
      slot_on[i] = 0;
      mode[i]    = NO_ACTIVITY;
      draw[i]    = '0;
    end
    for (int i = 0; i < CUR_DEPTH; i++) currents[i] = '0;
  endfunction

  function void write_reg(logic [CFG_IX_W-1:0] ix, logic [E_W-1:0] d);
    case (ix)
      CFG_VOLT: volt = d[VOLT_W-1:0];
      CFG_CAP: begin
        capacity = d;
        residual = d;
        snapshot = d;
      end
      CFG_THR: threshold = d;
      default: ;
    endcase
  endfunction

  // energy per millisecond of all active slots
  function logic [63:0] draw_rate();
    logic [63:0] sum;
    sum = '0;
    for (int i = 0; i < MAX_DEVICES; i++)
      if (slot_on[i] && mode[i] != NO_ACTIVITY) sum += 64'(draw[i]) * 64'(volt);
    return sum;
  endfunction

  function logic [63:0] drain_at(logic [TIME_W-1:0] now);
    logic [127:0]      prod;
    logic [64:0]       acc;
    logic [63:0]       total;
    logic [TIME_W-1:0] dt;
    dt = (now >= last_t) ? now - last_t : '0;
    total = '0;
    for (int i = 0; i < MAX_DEVICES; i++) begin
      if (slot_on[i] && mode[i] != NO_ACTIVITY) begin
        prod = 128'(draw[i]) * 128'(volt) * 128'(dt);
        if (prod[127:64] != 0) prod = 128'({64{1'b1}});
        acc = 65'(total) + 65'(prod[63:0]);
        total = acc[64] ? {64{1'b1}} : acc[63:0];
      end
    end
    return total;
  endfunction

  function void deduct(logic [TIME_W-1:0] now);
    logic [63:0] total;
    total = drain_at(now);
    last_t = now;
    if (total >= 64'(residual)) begin
      residual = '0;
      dead     = 1;
      dead_t   = now;
    end else begin
      residual = residual - total[E_W-1:0];
      if (snapshot >= residual && snapshot - residual >= threshold) snapshot = residual;
    end
  endfunction

  function void note_item(item_t it);
    status_t st;
    result_t want;
    st = STAT_OK;
    if (dead || residual == 0) begin
      st = STAT_DEAD;
    end else begin
      case (it.opcode)
        OP_REG: begin
          if (int'(it.device_slot) >= MAX_DEVICES) begin
            st = STAT_UNREG;
          end else if (slot_on[it.device_slot]) begin
            st = STAT_DUP;
          end else begin
            currents[{it.device_slot, ACT_IDLE}]  = it.idle_current;
            currents[{it.device_slot, ACT_RX}]    = it.receive_current;
            currents[{it.device_slot, ACT_TX}]    = it.transmit_current;
            currents[{it.device_slot, ACT_SLEEP}] = it.sleep_current;
            slot_on[it.device_slot] = 1;
          end
        end
        OP_ACT: begin
          if (int'(it.device_slot) >= MAX_DEVICES || !slot_on[it.device_slot]) begin
            st = STAT_UNREG;
          end else begin
            deduct(it.now_time);
            draw[it.device_slot] = currents[{it.device_slot, it.activity}];
            mode[it.device_slot] = {1'b0, it.activity};
          end
        end
        default: begin
          deduct(it.now_time);
          if (it.opcode == OP_PUB && !dead) snapshot = residual;
        end
      endcase
    end
    want.residual_out   = residual;
    want.snapshot_out   = snapshot;
    want.depleted       = dead;
    want.depletion_time = dead ? dead_t : '0;
    want.status         = st;
    readings.push_back(want);
  endfunction

  function void report_miss(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function void check_result(result_t got);
    result_t want;
    if (readings.size() == 0) begin
      report_miss($sformatf("reading with none awaited: res=%0d snap=%0d st=%0d",
                            got.residual_out, got.snapshot_out, got.status));
      return;
    end
    want = readings.pop_front();
    if (got.residual_out !== want.residual_out || got.snapshot_out !== want.snapshot_out ||
        got.depleted !== want.depleted || got.depletion_time !== want.depletion_time ||
        got.status !== want.status)
      report_miss($sformatf(
        "bad reading: exp res=%0d snap=%0d dep=%0b t=%0d st=%0d got res=%0d snap=%0d dep=%0b t=%0d st=%0d",
        want.residual_out, want.snapshot_out, want.depleted, want.depletion_time, want.status,
        got.residual_out, got.snapshot_out, got.depleted, got.depletion_time, got.status));
  endfunction

  function int pending();
    return readings.size();
  endfunction
endclass

module tb;
  localparam logic [CFG_IX_W-1:0] CFG_SPARE = CFG_IX_W'(3);
  localparam int PHASE_ITEMS = 270;
  localparam int LAST_ITEMS  = 150;

  logic                clk;
  logic                rst;
  logic                start;
  item_t               item;
  logic                busy;
  logic                done;
  result_t             result;
  logic                cfg_we;
  logic [CFG_IX_W-1:0] cfg_index;
  logic [E_W-1:0]      cfg_data;

  gauge_board sb = new();
  bit no_gaps;
  int idle_pct;
  int sent;

  battery_energy_accountant_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .busy     (busy),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  function logic [E_W-1:0] rand56();
    return E_W'({$urandom, $urandom});
  endfunction

  function logic [CUR_W-1:0] rand_cur();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return CUR_W'($urandom);
    endcase
  endfunction

  function item_t make_item(opcode_t op, logic [SLOT_W-1:0] slot, activity_t a,
                            logic [TIME_W-1:0] now);
    item_t it;
    it.opcode           = op;
    it.now_time         = now;
    it.device_slot      = slot;
    it.activity         = a;
    it.idle_current     = rand_cur();
    it.receive_current  = rand_cur();
    it.transmit_current = rand_cur();
    it.sleep_current    = rand_cur();
    return it;
  endfunction

  // pace time by the current drain so the battery outlives the random part
  function item_t random_item();
    item_t             it;
    int                slots [$];
    int                pick;
    opcode_t           op;
    logic [63:0]       rate;
    logic [63:0]       lim;
    logic [TIME_W-1:0] now;
    pick = $urandom_range(99);
    if (pick < 10) op = OP_REG;
    else if (pick < 50) op = OP_ACT;
    else if (pick < 80) op = OP_TICK;
    else op = OP_PUB;
    rate = sb.draw_rate();
    if (rate == 0) lim = 5000;
    else lim = 64'(sb.residual) / (rate * (($urandom_range(3) == 0) ? 300 : 4000));
    if (lim > 65535) lim = 65535;
    if (lim > 64'(32'hFFFF_FFFF - sb.last_t)) lim = 64'(32'hFFFF_FFFF - sb.last_t);
    now = sb.last_t + $urandom_range(0, 32'(lim));
    if ($urandom_range(49) == 0) begin
      // step time back
      if (sb.last_t > 1000) now = sb.last_t - $urandom_range(1, 1000);
      else now = '0;
    end
    it = make_item(op, SLOT_W'($urandom_range(7)), activity_t'($urandom_range(3)), now);
    if (op == OP_ACT && $urandom_range(99) < 85) begin
      for (int i = 0; i < MAX_DEVICES; i++) if (sb.slot_on[i]) slots.push_back(i);
      if (slots.size() > 0) it.device_slot = SLOT_W'(slots[$urandom_range(slots.size() - 1)]);
    end
    return it;
  endfunction

  task automatic send_item(item_t it);
    if (!no_gaps && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    start = 1'b1;
    item  = it;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(it);
    @(negedge clk);
    start = 1'b0;
    sent++;
    if (sent % 64 == 0) begin
      case ($urandom_range(2))
        0: idle_pct = 0;
        1: idle_pct = 30;
        default: idle_pct = 70;
      endcase
    end
  endtask

  task automatic write_reg(logic [CFG_IX_W-1:0] ix, logic [E_W-1:0] d);
    cfg_we    = 1'b1;
    cfg_index = ix;
    cfg_data  = d;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(ix, d);
  endtask

  // hold the sender until every beat has been answered
  task automatic settle();
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_setting(int p);
    logic [E_W-1:0] cap;
    settle();
    case (p)
      0: begin
        write_reg(CFG_VOLT, E_W'(16'hFFFF));
        write_reg(CFG_CAP, '1);
        write_reg(CFG_THR, '0);
      end
      1: begin
        write_reg(CFG_VOLT, '0);
        write_reg(CFG_CAP, E_W'(1));
        write_reg(CFG_THR, '1);
      end
      2: begin
        cap = rand56() | (E_W'(1) << 50);
        write_reg(CFG_VOLT, E_W'($urandom_range(1, 65535)));
        write_reg(CFG_CAP, cap);
        write_reg(CFG_THR, cap >> $urandom_range(4, 12));
      end
      3: begin
        write_reg(CFG_VOLT, E_W'(1));
        write_reg(CFG_CAP, rand56() | (E_W'(1) << 30));
        write_reg(CFG_THR, E_W'(1));
      end
      4: begin
        write_reg(CFG_VOLT, E_W'($urandom_range(0, 65535)));
        write_reg(CFG_CAP, rand56() | (E_W'(1) << 45));
        write_reg(CFG_THR, rand56());
      end
      default: begin
        cap = rand56() | (E_W'(1) << 52);
        write_reg(CFG_VOLT, E_W'(3000));
        write_reg(CFG_CAP, cap);
        write_reg(CFG_THR, cap >> 8);
      end
    endcase
  endtask

  initial begin
    item_t             it;
    logic [63:0]       rate;
    logic [63:0]       lim;
    logic [63:0]       drain;
    logic [TIME_W-1:0] dt;
    logic [TIME_W-1:0] t;

    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    no_gaps   = 0;
    idle_pct  = 30;
    sent      = 0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // the unused index must leave everything alone
    write_reg(CFG_SPARE, rand56());

    send_item(make_item(OP_TICK, 0, ACT_IDLE, 0));
    send_item(make_item(OP_ACT, 3, ACT_RX, 0));
    it = make_item(OP_REG, 0, ACT_IDLE, 10);
    it.idle_current     = '1;
    it.receive_current  = '1;
    it.transmit_current = '1;
    it.sleep_current    = '1;
    send_item(it);
    it = make_item(OP_REG, 0, ACT_IDLE, 10);
    it.idle_current     = '0;
    it.receive_current  = '0;
    it.transmit_current = '0;
    it.sleep_current    = '0;
    send_item(it);
    it.device_slot = 1;
    send_item(it);
    send_item(make_item(OP_REG, 7, ACT_SLEEP, 10));
    // nothing active yet: the largest time drains nothing, then time wraps back
    send_item(make_item(OP_TICK, 2, ACT_TX, 32'hFFFF_FFFF));
    send_item(make_item(OP_TICK, 5, ACT_SLEEP, 0));
    send_item(make_item(OP_ACT, 0, ACT_IDLE, 100));
    send_item(make_item(OP_TICK, 0, ACT_IDLE, 200));
    send_item(make_item(OP_ACT, 0, ACT_RX, 300));
    send_item(make_item(OP_ACT, 0, ACT_TX, 400));
    send_item(make_item(OP_ACT, 0, ACT_SLEEP, 500));
    send_item(make_item(OP_ACT, 1, ACT_TX, 600));
    send_item(make_item(OP_PUB, 4, ACT_RX, 700));
    send_item(make_item(OP_TICK, 6, ACT_IDLE, 650));
    send_item(make_item(OP_ACT, 7, ACT_RX, 650));
    send_item(make_item(OP_PUB, 3, ACT_TX, 2000));
    send_item(make_item(OP_REG, 2, ACT_IDLE, 2000));
    // drop past the default threshold
    send_item(make_item(OP_TICK, 1, ACT_RX, 100000));
    send_item(make_item(OP_TICK, 1, ACT_RX, 100001));

    for (int p = 0; p < 6; p++) begin
      apply_setting(p);
      if (p == 5) no_gaps = 1;
      repeat ((p == 5) ? LAST_ITEMS : PHASE_ITEMS) send_item(random_item());
    end

    settle();
    write_reg(CFG_VOLT, E_W'($urandom_range(1000, 65535)));
    send_item(make_item(OP_ACT, 0, activity_t'($urandom_range(3)), sb.last_t));

    // leave exactly one picojoule
    settle();
    rate = sb.draw_rate();
    lim = ((64'd1 << E_W) - 2) / rate;
    dt = (lim < 1000) ? TIME_W'(lim) : TIME_W'(1000);
    t = sb.last_t + dt;
    drain = sb.drain_at(t);
    write_reg(CFG_CAP, E_W'(drain + 1));
    send_item(make_item(OP_TICK, 3, ACT_IDLE, t));
    send_item(make_item(OP_PUB, 3, ACT_IDLE, t));

    // deplete either on an exact match or on a saturated product
    settle();
    if ($urandom_range(1) == 0) begin
      t = sb.last_t + dt;
      drain = sb.drain_at(t);
      write_reg(CFG_CAP, E_W'(drain));
    end else begin
      write_reg(CFG_VOLT, E_W'(16'hFFFF));
      write_reg(CFG_CAP, '1);
      t = 32'hFFFF_FFFF;
    end
    it = make_item(OP_TICK, 0, activity_t'($urandom_range(3)), t);
    case ($urandom_range(2))
      0: it.opcode = OP_ACT;
      1: it.opcode = OP_PUB;
      default: ;
    endcase
    send_item(it);

    repeat (20) send_item(make_item(opcode_t'($urandom_range(3)), SLOT_W'($urandom_range(7)),
                                    activity_t'($urandom_range(3)), $urandom));
    settle();
    write_reg(CFG_VOLT, rand56());
    write_reg(CFG_CAP, rand56() | E_W'(1));
    write_reg(CFG_THR, rand56());
    repeat (10) send_item(make_item(opcode_t'($urandom_range(3)), SLOT_W'($urandom_range(7)),
                                    activity_t'($urandom_range(3)), $urandom));

    while (sb.pending() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("battery_energy_accountant_unit: match");
    end else begin
      $display("battery_energy_accountant_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("battery_energy_accountant_unit: mismatch");
    $finish;
  end
endmodule
